>>> hdl/wsil_pkg.sv
// Shared constants for the interpolating waveshaper.
`timescale 1ns / 1ps

package wsil_pkg;

    // Default sizing of the curve store and of the sample path.
    localparam int MAX_CURVE_DEF    = 1024;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Fixed field widths.
    localparam int INDEX_W = 10;
    localparam int LEN_W   = 11;

    // Configuration port sizing and register map (word index = paddr >> 2).
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REGIDX_W = PADDR_W - 2;
    localparam logic [REGIDX_W-1:0] REG_SHAPE_LEN = '0;

    // Item commands.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

endpackage

>>> hdl/wsil_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module wsil_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, data registered and held while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/wsil_cfg.sv
// Configuration register block: curve length and its derived lookup controls.
`timescale 1ns / 1ps

module wsil_cfg #(
    parameter int MAX_CURVE = wsil_pkg::MAX_CURVE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsil_pkg::PADDR_W-1:0]  paddr,
    input  logic [wsil_pkg::PDATA_W-1:0]  pwdata,
    output logic [wsil_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic                          passthru,
    output logic [$clog2(MAX_CURVE)-1:0]  len_m1
);

    localparam int AW = $clog2(MAX_CURVE);

    logic [wsil_pkg::LEN_W-1:0]    shape_len_reg;
    logic [wsil_pkg::REGIDX_W-1:0] reg_idx;
    logic                          wr_en;
    logic [31:0]                   len_eff;

    assign pready  = 1'b1;
    assign reg_idx = paddr[wsil_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register write on the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_len_reg <= '0;
        end
        else if (wr_en && (reg_idx == wsil_pkg::REG_SHAPE_LEN))
        begin
            shape_len_reg <= pwdata[wsil_pkg::LEN_W-1:0];
        end
    end

    // Read data.
    assign prdata = (reg_idx == wsil_pkg::REG_SHAPE_LEN) ?
                    wsil_pkg::PDATA_W'(shape_len_reg) : '0;

    // The length in use saturates at the store depth; zero selects pass-through.
    always_comb
    begin
        if (32'(shape_len_reg) > 32'(MAX_CURVE))
        begin
            len_eff = 32'(MAX_CURVE);
        end
        else
        begin
            len_eff = 32'(shape_len_reg);
        end
    end

    assign passthru = (len_eff == 32'd0);
    assign len_m1   = AW'(len_eff - 32'd1);

endmodule

>>> hdl/waveshaper_interp_lookup_top.sv
// Top level of the interpolating waveshaper: lookup pipeline around the curve store.
`timescale 1ns / 1ps

// Usage:
// Input beats carry cmd plus the sample and curve-write fields on in_valid/in_ready.
// A write beat (cmd = 1) stores entry_value at entry_index and yields no output;
// indexes at or beyond MAX_CURVE are dropped. A sample beat (cmd = 0) yields one
// output beat on out_valid/out_ready carrying sample_out and result_last.
// The curve store is two mirrored RAMs with registered reads, so the
// lower and upper interpolation points are fetched in the same cycle.
// Pipeline: the position multiply is registered when a sample is accepted, then
// the RAM read, the slope multiply and the sum are each registered in turn, and
// any stage can hold under backpressure.
// Throughput: one beat per cycle while out_ready is high, writes and samples in any
// order; each stage has its own valid bit, so bubbles close up under backpressure.
// When out_ready is low the stages fill up and in_ready drops only once the
// input stage cannot move forward.
// Reset clears the pipeline valids and sets the curve length register to 0
// (pass-through). Curve entries are undefined until written. Write the curve length
// register over APB only while no sample is in flight; the block does not enforce it.
module waveshaper_interp_lookup_top #(
    parameter int MAX_CURVE    = wsil_pkg::MAX_CURVE_DEF,
    parameter int SAMPLE_WIDTH = wsil_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input channel.
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             cmd,
    input  logic signed [SAMPLE_WIDTH-1:0]   sample_in,
    input  logic [wsil_pkg::INDEX_W-1:0]     entry_index,
    input  logic signed [SAMPLE_WIDTH-1:0]   entry_value,
    input  logic                             block_last,
    // Output channel.
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]   sample_out,
    output logic                             result_last,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wsil_pkg::PADDR_W-1:0]     paddr,
    input  logic [wsil_pkg::PDATA_W-1:0]     pwdata,
    output logic [wsil_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int FBITS = SW - 1;
    localparam int AW    = $clog2(MAX_CURVE);
    localparam int PW    = SW + AW;
    localparam int PRW   = 2 * SW + 1;
    localparam logic signed [SW-1:0] POS_ONE = SW'(1 << (SW - 2));
    localparam logic signed [SW-1:0] NEG_ONE = -POS_ONE;

    // Configuration.
    logic          passthru;
    logic [AW-1:0] len_m1;

    wsil_cfg #(
        .MAX_CURVE (MAX_CURVE)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .passthru (passthru),
        .len_m1   (len_m1)
    );

    // Stage valids and handshake moves.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic in_fire, m12, m23, m34;
    logic s2_free, s3_free;
    logic cmd1_reg;

    assign m34     = v3_reg && (!v4_reg || out_ready);
    assign s3_free = !v3_reg || m34;
    assign m23     = v2_reg && s3_free;
    assign s2_free = !v2_reg || m23;
    assign m12     = v1_reg && s2_free;
    assign in_ready = !v1_reg || m12;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                v1_reg <= 1'b1;
            end
            else if (m12)
            begin
                v1_reg <= 1'b0;
            end

            // A write beat retires when it reaches the RAM port.
            if (m12)
            begin
                v2_reg <= (cmd1_reg == wsil_pkg::CMD_SAMPLE);
            end
            else if (m23)
            begin
                v2_reg <= 1'b0;
            end

            if (m23)
            begin
                v3_reg <= 1'b1;
            end
            else if (m34)
            begin
                v3_reg <= 1'b0;
            end

            if (m34)
            begin
                v4_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                v4_reg <= 1'b0;
            end
        end
    end

    // Stage 0: clamp to plus/minus one and scale onto the curve position.
    logic signed [SW-1:0] x_clamp;
    logic [SW-1:0]        u0;
    logic [PW-1:0]        p_next;

    always_comb
    begin
        if (sample_in < NEG_ONE)
        begin
            x_clamp = NEG_ONE;
        end
        else if (sample_in > POS_ONE)
        begin
            x_clamp = POS_ONE;
        end
        else
        begin
            x_clamp = sample_in;
        end
    end

    assign u0     = $unsigned(x_clamp) + $unsigned(POS_ONE);
    assign p_next = PW'(u0) * PW'(len_m1);

    // Stage 1 registers.
    logic [PW-1:0]              p1_reg;
    logic                       pass1_reg;
    logic [SW-1:0]              raw1_reg;
    logic                       last1_reg;
    logic [wsil_pkg::INDEX_W-1:0] widx1_reg;
    logic [SW-1:0]              wval1_reg;
    logic [AW-1:0]              lm1_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd1_reg  <= cmd;
            p1_reg    <= p_next;
            pass1_reg <= passthru;
            raw1_reg  <= sample_in;
            last1_reg <= block_last;
            widx1_reg <= entry_index;
            wval1_reg <= entry_value;
            lm1_reg   <= len_m1;
        end
    end

    // Stage 1: table addresses and the write port. The upper point repeats
    // the lower one at the last entry.
    logic [AW:0]    idx_full;
    logic [AW-1:0]  idx_lo, idx_hi;
    logic           wr_in_range, ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [SW-1:0]  rd_lo, rd_hi;

    assign idx_full    = p1_reg[PW-1:FBITS];
    assign idx_lo      = idx_full[AW-1:0];
    assign idx_hi      = (idx_lo < lm1_reg) ? idx_lo + AW'(1) : idx_lo;
    assign wr_in_range = 32'(widx1_reg) < 32'(MAX_CURVE);
    assign ram_waddr   = AW'(32'(widx1_reg));
    assign ram_we      = m12 && (cmd1_reg == wsil_pkg::CMD_WRITE) && wr_in_range;

    wsil_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_CURVE)
    ) u_ram_lo (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wval1_reg),
        .re    (m12),
        .raddr (idx_lo),
        .rdata (rd_lo)
    );

    wsil_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_CURVE)
    ) u_ram_hi (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wval1_reg),
        .re    (m12),
        .raddr (idx_hi),
        .rdata (rd_hi)
    );

    // Stage 2 registers, aligned with the RAM read data.
    logic [FBITS-1:0] frac2_reg;
    logic             pass2_reg;
    logic [SW-1:0]    raw2_reg;
    logic             last2_reg;

    always_ff @(posedge clk)
    begin
        if (m12)
        begin
            frac2_reg <= p1_reg[FBITS-1:0];
            pass2_reg <= pass1_reg;
            raw2_reg  <= raw1_reg;
            last2_reg <= last1_reg;
        end
    end

    // Stage 2: signed slope times fraction.
    logic signed [SW:0]     diff2;
    logic signed [PRW-1:0]  diff_ext, frac_ext, prod_next;

    assign diff2     = $signed({rd_hi[SW-1], rd_hi}) - $signed({rd_lo[SW-1], rd_lo});
    assign diff_ext  = PRW'(diff2);
    assign frac_ext  = PRW'($signed({1'b0, frac2_reg}));
    assign prod_next = diff_ext * frac_ext;

    // Stage 3 registers.
    logic signed [PRW-1:0] prod3_reg;
    logic [SW-1:0]         lo3_reg;
    logic                  pass3_reg;
    logic [SW-1:0]         raw3_reg;
    logic                  last3_reg;

    always_ff @(posedge clk)
    begin
        if (m23)
        begin
            prod3_reg <= prod_next;
            lo3_reg   <= rd_lo;
            pass3_reg <= pass2_reg;
            raw3_reg  <= raw2_reg;
            last3_reg <= last2_reg;
        end
    end

    // Stage 3: arithmetic shift rounds the step toward minus infinity.
    logic signed [PRW-1:0] delta3;
    logic [SW-1:0]         shaped3, out_next;

    assign delta3   = prod3_reg >>> FBITS;
    assign shaped3  = lo3_reg + delta3[SW-1:0];
    assign out_next = pass3_reg ? raw3_reg : shaped3;

    // Output register.
    logic [SW-1:0] sample_out_reg;
    logic          result_last_reg;

    always_ff @(posedge clk)
    begin
        if (m34)
        begin
            sample_out_reg  <= out_next;
            result_last_reg <= last3_reg;
        end
    end

    assign out_valid   = v4_reg;
    assign sample_out  = $signed(sample_out_reg);
    assign result_last = result_last_reg;

endmodule
